@@ rtl/core/tcw_pkg.sv @@
// Shared constants and types for the text console writer.
// Depends on nothing; every other design file apart from tcw_if refers to it by scoped names.
package tcw_pkg;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELLS       = SCREEN_ROWS * SCREEN_COLS;

    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int COL_W  = $clog2(SCREEN_COLS);
    localparam int ADDR_W = $clog2(CELLS);

    // APB: one register, byte addresses 4*i
    localparam int PADDR_W = 3;
    localparam logic REG_TEXT_ATTR = 1'b0;

    localparam logic [7:0] CODE_LF    = 8'd10;
    localparam logic [7:0] CODE_CR    = 8'd13;
    localparam logic [7:0] CODE_BS    = 8'd8;
    localparam logic [7:0] CODE_SPACE = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h07;

    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RWAIT,
        ST_SCROLL,
        ST_DRAIN,
        ST_BLANK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [4:0] cursor_y;
        logic [6:0] cursor_x;
    } t_result;

endpackage

@@ rtl/core/tcw_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing beyond the fixed field widths.
interface tcw_item_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;

    modport source (output valid, kind, char_code, read_row, read_col, input ready);
    modport sink   (input valid, kind, char_code, read_row, read_col, output ready);
endinterface

interface tcw_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [4:0] cursor_y;
    logic [6:0] cursor_x;

    modport source (output valid, cell_char, cell_attr, cursor_y, cursor_x, input ready);
    modport sink   (input valid, cell_char, cell_attr, cursor_y, cursor_x, output ready);
endinterface

@@ rtl/core/text_console_writer_unit.sv @@
// Top level of the text console writer: APB register, console engine, result register.
// Depends on tcw_pkg, tcw_if, tcw_cfg and tcw_core.
//
// Text-mode console with an 80x25 screen of 16-bit cells (character in the low
// byte, attribute in the high byte) held in one synchronous RAM with a read
// port and a write port, plus a cursor. After reset the block clears the
// screen to spaces with attribute 0x07; input ready stays low during that pass,
// APB writes are taken throughout. Items are handled one at a time: a put item
// passes through the EXEC and DONE states, a read item through EXEC, RWAIT (for
// the RAM read latency) and DONE. A put that moves the cursor past the bottom
// row scrolls the screen by copying rows 1..24 up one row, one cell per cycle
// through the RAM's read and write port, then blanking the bottom row. The RAM
// port is the bottleneck throughout. Results sit in an output register, so the
// next item is accepted while the previous result waits for the sink. The
// text_attribute register is at APB address 0 and should only be written while
// no item is in flight.
module text_console_writer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tcw_item_if.sink                    i_in,
    tcw_result_if.source                o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic             attr;
    logic [7:0]       text_attr;
    logic             res_vld;
    logic             res_free;
    tcw_pkg::t_result res;

    logic             r_out_vld;
    tcw_pkg::t_result r_out;

    tcw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_attr  (text_attr)
    );

    tcw_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_attr     (text_attr),
        .i_res_free (res_free),
        .o_res_vld  (res_vld),
        .o_res      (res)
    );

    // output register frees up in the same cycle the sink takes it
    assign res_free = !r_out_vld || o_out.ready;
    assign attr     = res_vld && res_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (attr) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (attr) begin
            r_out <= res;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.cell_char = r_out.cell_char;
    assign o_out.cell_attr = r_out.cell_attr;
    assign o_out.cursor_y  = r_out.cursor_y;
    assign o_out.cursor_x  = r_out.cursor_x;

endmodule

@@ rtl/core/tcw_cfg.sv @@
// APB configuration register: text attribute byte.
// Depends on tcw_pkg.
module tcw_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [7:0]                  o_attr
);

    logic [7:0] r_attr;
    logic       sel_attr;

    assign sel_attr = (paddr[2] == tcw_pkg::REG_TEXT_ATTR);
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::RESET_ATTR;
        end else if (psel && penable && pwrite && sel_attr) begin
            r_attr <= pwdata[7:0];
        end
    end

    assign prdata = sel_attr ? {24'd0, r_attr} : 32'd0;
    assign o_attr = r_attr;

endmodule

@@ rtl/core/tcw_core.sv @@
// Console engine: screen memory, cursor and the sequencer that works on it.
// Depends on tcw_pkg and tcw_if.
module tcw_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tcw_item_if.sink          i_in,
    input  logic [7:0]        i_attr,
    input  logic              i_res_free,
    output logic              o_res_vld,
    output tcw_pkg::t_result  o_res
);

    localparam int ROW_W  = tcw_pkg::ROW_W;
    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int ADDR_W = tcw_pkg::ADDR_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(tcw_pkg::CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(tcw_pkg::SCREEN_COLS);
    localparam logic [ADDR_W-1:0] BOT_ADDR  =
        ADDR_W'((tcw_pkg::SCREEN_ROWS - 1) * tcw_pkg::SCREEN_COLS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(tcw_pkg::SCREEN_ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(tcw_pkg::SCREEN_COLS - 1);

    // screen memory: char in low byte, attribute in high byte
    logic [15:0] r_mem [tcw_pkg::CELLS];
    logic [15:0] r_rd_data;

    tcw_pkg::t_state r_state, n_state;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_cp_vld, n_cp_vld;
    logic [ADDR_W-1:0] r_cp_dst, n_cp_dst;
    logic [ROW_W-1:0]  r_cur_row, n_cur_row;
    logic [COL_W-1:0]  r_cur_col, n_cur_col;
    logic [15:0]       r_cell, n_cell;
    logic              r_kind;
    logic [7:0]        r_char;
    logic [4:0]        r_rd_row;
    logic [6:0]        r_rd_col;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [15:0]       mem_wd;
    logic [ADDR_W-1:0] mem_ra;

    logic [ROW_W-1:0]  a_row;
    logic [COL_W-1:0]  a_col;
    logic [ADDR_W-1:0] cell_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    assign cell_addr = ADDR_W'(a_row) * ROW_STEP + ADDR_W'(a_col);

    assign i_in.ready = (r_state == tcw_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tcw_pkg::ST_CLEAR;
            r_addr    <= '0;
            r_cp_vld  <= 1'b0;
            r_cur_row <= '0;
            r_cur_col <= '0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_cp_vld  <= n_cp_vld;
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_dst <= n_cp_dst;
        r_cell   <= n_cell;
        if (i_in.valid && i_in.ready) begin
            r_kind   <= i_in.kind;
            r_char   <= i_in.char_code;
            r_rd_row <= i_in.read_row;
            r_rd_col <= i_in.read_col;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_cp_vld  = r_cp_vld;
        n_cp_dst  = r_cp_dst;
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        n_cell    = r_cell;
        mem_we    = 1'b0;
        mem_wa    = r_addr;
        mem_wd    = {i_attr, tcw_pkg::CODE_SPACE};
        mem_ra    = r_addr;
        a_row     = r_cur_row;
        a_col     = r_cur_col;
        o_res_vld = 1'b0;

        unique case (r_state)
            tcw_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wd = {tcw_pkg::RESET_ATTR, tcw_pkg::CODE_SPACE};
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = tcw_pkg::ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_EXEC: begin
                if (r_kind == tcw_pkg::KIND_READ) begin
                    // clamp to the last row / column
                    a_row   = (r_rd_row > 5'(LAST_ROW)) ? LAST_ROW : ROW_W'(r_rd_row);
                    a_col   = (r_rd_col > 7'(LAST_COL)) ? LAST_COL : COL_W'(r_rd_col);
                    mem_ra  = cell_addr;
                    n_state = tcw_pkg::ST_RWAIT;
                end else begin
                    n_cell  = '0;
                    n_state = tcw_pkg::ST_DONE;
                    priority if (r_char == tcw_pkg::CODE_LF) begin
                        n_cur_col = '0;
                        if (r_cur_row == LAST_ROW) begin
                            n_state = tcw_pkg::ST_SCROLL;
                        end else begin
                            n_cur_row = r_cur_row + 1'b1;
                        end
                    end else if (r_char == tcw_pkg::CODE_CR) begin
                        n_cur_col = '0;
                    end else if (r_char == tcw_pkg::CODE_BS) begin
                        if (r_cur_col != '0) begin
                            a_col     = r_cur_col - 1'b1;
                            n_cur_col = a_col;
                            mem_we    = 1'b1;
                            mem_wa    = cell_addr;
                        end else if (r_cur_row != '0) begin
                            a_row     = r_cur_row - 1'b1;
                            a_col     = LAST_COL;
                            n_cur_row = a_row;
                            n_cur_col = LAST_COL;
                            mem_we    = 1'b1;
                            mem_wa    = cell_addr;
                        end
                    end else begin
                        mem_we = 1'b1;
                        mem_wa = cell_addr;
                        mem_wd = {i_attr, r_char};
                        if (r_cur_col == LAST_COL) begin
                            n_cur_col = '0;
                            if (r_cur_row == LAST_ROW) begin
                                n_state = tcw_pkg::ST_SCROLL;
                            end else begin
                                n_cur_row = r_cur_row + 1'b1;
                            end
                        end else begin
                            n_cur_col = r_cur_col + 1'b1;
                        end
                    end
                    if (n_state == tcw_pkg::ST_SCROLL) begin
                        n_addr   = ROW_STEP;
                        n_cp_vld = 1'b0;
                    end
                end
            end
            tcw_pkg::ST_RWAIT: begin
                n_cell  = r_rd_data;
                n_state = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_SCROLL: begin
                // read one row below, write back the cell read last cycle
                mem_ra   = r_addr;
                n_cp_vld = 1'b1;
                n_cp_dst = r_addr - ROW_STEP;
                mem_we   = r_cp_vld;
                mem_wa   = r_cp_dst;
                mem_wd   = r_rd_data;
                if (r_addr == LAST_ADDR) begin
                    n_state = tcw_pkg::ST_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            tcw_pkg::ST_DRAIN: begin
                mem_we   = 1'b1;
                mem_wa   = r_cp_dst;
                mem_wd   = r_rd_data;
                n_cp_vld = 1'b0;
                n_addr   = BOT_ADDR;
                n_state  = tcw_pkg::ST_BLANK;
            end
            tcw_pkg::ST_BLANK: begin
                mem_we = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = tcw_pkg::ST_DONE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            tcw_pkg::ST_DONE: begin
                if (i_res_free) begin
                    o_res_vld = 1'b1;
                    n_state   = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_res.cell_char = r_cell[7:0];
    assign o_res.cell_attr = r_cell[15:8];
    assign o_res.cursor_y  = 5'(r_cur_row);
    assign o_res.cursor_x  = 7'(r_cur_col);

endmodule
